[rtl/core/fifo_evicting_id_hash_set_core_defines.svh]
// Assertion macros for the identifier hash set core.
// Depends on nothing; included by the core module only.
`ifndef FIFO_EVICTING_ID_HASH_SET_CORE_DEFINES_SVH
`define FIFO_EVICTING_ID_HASH_SET_CORE_DEFINES_SVH
`define FEHS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define FEHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/fehs_pkg.sv]
// Package for the identifier hash set core: types, codes and defaults.
// Depends on nothing.
package fehs_pkg;
  localparam int unsigned RingDepthDefault  = 256;
  localparam int unsigned TableDepthDefault = 512;
  localparam int unsigned IdW = 64;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_LOC_RD,
    ST_LOC_WT,
    ST_LOC_RING,
    ST_LOC_CMP,
    ST_ADD_DEC,
    ST_EV_RD,
    ST_EV_WT,
    ST_EV_LOC_RD,
    ST_EV_LOC_WT,
    ST_EV_LOC_RING,
    ST_EV_LOC_CMP,
    ST_SH_RD,
    ST_SH_WT,
    ST_SH_RING,
    ST_SH_DEC,
    ST_SH_END,
    ST_WR_RING,
    ST_IX_RD,
    ST_IX_WT,
    ST_RD_RD,
    ST_RD_WT,
    ST_SH_MOVE
  } state_t;
endpackage

[rtl/core/fifo_evicting_id_hash_set_core.sv]
// Lookup: each occupied slot probed is read from the table, then the ring, then compared; a
// miss ends at an empty slot and the decision. Add: a lookup miss; when full, eviction finds
// the oldest entry's slot, shifts its cluster back and clears the hole; then the ring write and
// a probe for an empty slot for the index. Clear sweeps the table. The result shows the cycle
// after; one word at a time, a new one taken once the result has gone. One table port and one
// ring port. Reset clears control state and starts a table sweep; the ring is not reset.
module fifo_evicting_id_hash_set_core
  import fehs_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RingDepthDefault,
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  input  logic [IdW-1:0] id_high,
  input  logic [IdW-1:0] id_low,
  input  logic [7:0]    read_index,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          hit,
  output logic          index_ok,
  output logic [8:0]    entry_count,
  output logic [IdW-1:0] read_high,
  output logic [IdW-1:0] read_low
);
  `include "fifo_evicting_id_hash_set_core_defines.svh"

  localparam int unsigned RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned TW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [EW-1:0] Full = EW'(RING_DEPTH);
  localparam logic [TW-1:0] TLast = TW'(TABLE_DEPTH - 1);
  localparam logic [RW-1:0] RLast = RW'(RING_DEPTH - 1);

  logic [EW-1:0] tmem [TABLE_DEPTH];
  logic [IdW-1:0] rhi [RING_DEPTH];
  logic [IdW-1:0] rlo [RING_DEPTH];

  state_t state, state_next;
  logic [TW-1:0] ta, ta_next;
  logic          twe;
  logic [EW-1:0] twd, tq;
  logic [RW-1:0] ra;
  logic          rwe;
  logic [IdW-1:0] rqh, rql;

  logic [1:0]    act;
  logic [IdW-1:0] kh, kl, eh, el;
  logic [7:0]    ridx;
  logic [RW-1:0] oldest, oldest_next, pos, pos_next;
  logic [EW-1:0] cnt, cnt_next, ent, ent_next;
  logic [TW-1:0] hole, hole_next, home, home_next;
  logic [CW-1:0] steps, steps_next;
  logic          hit_next, ok_next, res_ld;
  logic [IdW-1:0] oh_next, ol_next;
  logic          cap_key, cap_ev, cap_ent, hole_ld;

  function automatic logic [TW-1:0] inc_t(input logic [TW-1:0] s);
    return (s == TLast) ? '0 : s + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (twe) tmem[ta] <= twd;
    tq <= tmem[ta];
    if (rwe) begin
      rhi[ra] <= kh;
      rlo[ra] <= kl;
    end
    rqh <= rhi[ra];
    rql <= rlo[ra];
  end

  logic [RW-1:0] rpos_sum;
  logic [RW:0]   rsum;
  logic [RW:0]   apsum;
  logic [RW-1:0] apos;
  assign rsum  = {1'b0, oldest} + (RW+1)'(ridx);
  assign rpos_sum = (rsum >= (RW+1)'(RING_DEPTH)) ? RW'(rsum - (RW+1)'(RING_DEPTH)) : RW'(rsum);
  assign apsum = {1'b0, oldest} + (RW+1)'(cnt);
  assign apos  = (apsum >= (RW+1)'(RING_DEPTH)) ? RW'(apsum - (RW+1)'(RING_DEPTH)) : RW'(apsum);

  logic [TW-1:0] sh_home, dn, dh;
  assign sh_home = TW'(rqh ^ rql);
  assign dn = ta - sh_home;
  assign dh = hole - sh_home;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLR;
      oldest <= '0;
      cnt    <= '0;
      ta     <= '0;
      act    <= ACT_LOOKUP;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      cnt    <= cnt_next;
      ta     <= ta_next;
      if (cap_key) act <= action;
      if (res_ld) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_key) begin
      kh <= id_high; kl <= id_low; ridx <= read_index;
    end
    if (cap_ev) begin
      eh <= rqh; el <= rql;
    end
    if (cap_ent) ent <= ent_next;
    if (hole_ld) hole <= hole_next;
    home  <= home_next;
    pos   <= pos_next;
    steps <= steps_next;
    if (res_ld) begin
      hit <= hit_next; index_ok <= ok_next; entry_count <= 9'(cnt_next);
      read_high <= oh_next; read_low <= ol_next;
    end
  end

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    ta_next = ta; twe = 1'b0; twd = '0;
    ra = pos; rwe = 1'b0;
    oldest_next = oldest; cnt_next = cnt; pos_next = pos;
    ent_next = tq; hole_next = hole; home_next = home; steps_next = steps;
    cap_key = 1'b0; cap_ev = 1'b0; cap_ent = 1'b0; hole_ld = 1'b0;
    res_ld = 1'b0; hit_next = 1'b0; ok_next = 1'b0; oh_next = '0; ol_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cap_key = 1'b1;
          steps_next = '0;
          ta_next = TW'(id_high ^ id_low);
          unique case (action_t'(action))
            ACT_ADD, ACT_LOOKUP: state_next = ST_LOC_RD;
            ACT_READ: state_next = ST_RD_RD;
            ACT_CLEAR: begin
              ta_next = '0;
              state_next = ST_CLR;
            end
          endcase
        end
      end
      ST_CLR: begin
        twe = 1'b1; twd = '0;
        oldest_next = '0; cnt_next = '0;
        ta_next = inc_t(ta);
        if (ta == TLast) begin
          if (act == ACT_CLEAR) begin
            res_ld = 1'b1;
            cnt_next = '0;
          end
          state_next = ST_IDLE;
        end
      end
      ST_LOC_RD: state_next = ST_LOC_WT;
      ST_LOC_WT: begin
        cap_ent = 1'b1;
        if (tq == '0 || steps == CW'(TABLE_DEPTH)) state_next = ST_ADD_DEC;
        else if (tq - 1'b1 >= Full) begin
          state_next = ST_LOC_CMP; ent_next = '0;
        end else begin
          pos_next = RW'(tq - 1'b1);
          state_next = ST_LOC_RING;
        end
      end
      ST_LOC_RING: begin
        ra = pos;
        state_next = ST_LOC_CMP;
      end
      ST_LOC_CMP: begin
        if (ent != '0 && rqh == kh && rql == kl) begin
          res_ld = 1'b1; hit_next = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ta_next = inc_t(ta);
          steps_next = steps + 1'b1;
          state_next = ST_LOC_RD;
        end
      end
      ST_ADD_DEC: begin
        if (act == ACT_LOOKUP) begin
          res_ld = 1'b1; state_next = ST_IDLE;
        end else if (cnt != Full) begin
          pos_next = apos; cnt_next = cnt + 1'b1;
          state_next = ST_WR_RING;
        end else begin
          pos_next = oldest;
          oldest_next = (oldest == RLast) ? '0 : oldest + 1'b1;
          state_next = ST_EV_RD;
        end
      end
      ST_EV_RD: begin ra = pos; state_next = ST_EV_WT; end
      ST_EV_WT: begin
        cap_ev = 1'b1;
        ta_next = TW'(rqh ^ rql);
        steps_next = '0;
        state_next = ST_EV_LOC_RD;
      end
      ST_EV_LOC_RD: state_next = ST_EV_LOC_WT;
      ST_EV_LOC_WT: begin
        cap_ent = 1'b1;
        if (tq == '0 || steps == CW'(TABLE_DEPTH)) state_next = ST_WR_RING;
        else if (tq - 1'b1 >= Full) begin
          ent_next = '0; state_next = ST_EV_LOC_CMP;
        end else begin
          home_next = TW'(tq - 1'b1);
          state_next = ST_EV_LOC_RING;
        end
      end
      ST_EV_LOC_RING: begin
        ra = RW'(home);
        state_next = ST_EV_LOC_CMP;
      end
      ST_EV_LOC_CMP: begin
        if (ent != '0 && rqh == eh && rql == el) begin
          hole_ld = 1'b1; hole_next = ta;
          ta_next = inc_t(ta);
          steps_next = '0;
          state_next = ST_SH_RD;
        end else begin
          ta_next = inc_t(ta);
          steps_next = steps + 1'b1;
          state_next = ST_EV_LOC_RD;
        end
      end
      ST_SH_RD: state_next = ST_SH_WT;
      ST_SH_WT: begin
        cap_ent = 1'b1;
        if (tq == '0 || tq - 1'b1 >= Full || steps == CW'(TABLE_DEPTH)) begin
          ta_next = hole;
          state_next = ST_SH_END;
        end else state_next = ST_SH_RING;
      end
      ST_SH_RING: begin
        ra = RW'(ent - 1'b1);
        state_next = ST_SH_DEC;
      end
      ST_SH_DEC: begin
        if (dh < dn) begin
          hole_ld = 1'b1; hole_next = ta;
          ta_next = hole;
          state_next = ST_SH_MOVE;
        end else begin
          ta_next = inc_t(ta);
          steps_next = steps + 1'b1;
          state_next = ST_SH_RD;
        end
      end
      ST_SH_MOVE: begin
        twe = 1'b1; twd = ent;
        ta_next = inc_t(hole);
        steps_next = steps + 1'b1;
        state_next = ST_SH_RD;
      end
      ST_SH_END: begin
        twe = 1'b1; twd = '0;
        ta_next = TW'(kh ^ kl);
        steps_next = '0;
        state_next = ST_WR_RING;
      end
      ST_WR_RING: begin
        ra = pos; rwe = 1'b1;
        ta_next = TW'(kh ^ kl);
        steps_next = '0;
        state_next = ST_IX_RD;
      end
      ST_IX_RD: state_next = ST_IX_WT;
      ST_IX_WT: begin
        if (tq == '0) begin
          twe = 1'b1; twd = EW'(pos) + 1'b1;
          res_ld = 1'b1; state_next = ST_IDLE;
        end else if (steps == CW'(TABLE_DEPTH - 1)) begin
          res_ld = 1'b1; state_next = ST_IDLE;
        end else begin
          ta_next = inc_t(ta);
          steps_next = steps + 1'b1;
          state_next = ST_IX_RD;
        end
      end
      ST_RD_RD: begin
        pos_next = rpos_sum; ra = rpos_sum;
        state_next = ST_RD_WT;
      end
      ST_RD_WT: begin
        res_ld = 1'b1;
        if (EW'(ridx) < cnt) begin
          ok_next = 1'b1; oh_next = rqh; ol_next = rql;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `FEHS_ASSERT_IMPL(a_cnt_range, 1'b1, cnt <= Full, "entry count above ring depth")
  `FEHS_ASSERT_IMPL(a_busy_not_ready, state != ST_IDLE, !in_ready, "ready while busy")
  `FEHS_ASSERT_NEXT(a_one_result, res_ld, out_valid, "result not presented")
endmodule

[tb/sv/fehs_checker.sv]
// Checker for the identifier hash set core: watches both channels, predicts each result
// word and compares it as a whole with the word taken. Depends on fehs_pkg.
module fehs_checker
  import fehs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic [1:0]     action,
  input  logic [IdW-1:0] id_high,
  input  logic [IdW-1:0] id_low,
  input  logic [7:0]     read_index,
  input  logic           out_valid,
  input  logic           out_ready,
  input  logic           hit,
  input  logic           index_ok,
  input  logic [8:0]     entry_count,
  input  logic [IdW-1:0] read_high,
  input  logic [IdW-1:0] read_low,
  output int             fail_count,
  output int             pending
);
  localparam int RING = RingDepthDefault;
  localparam int TBL  = TableDepthDefault;

  typedef struct packed {
    logic           hit;
    logic           index_ok;
    logic [8:0]     entry_count;
    logic [IdW-1:0] read_high;
    logic [IdW-1:0] read_low;
  } answer_t;

  logic [IdW-1:0] ring_hi [RING];
  logic [IdW-1:0] ring_lo [RING];
  logic [8:0]     slots [TBL];
  int             oldest;
  int             held;
  answer_t        answers [$];

  function automatic int bucket(logic [IdW-1:0] h, logic [IdW-1:0] l);
    logic [IdW-1:0] x;
    x = h ^ l;
    return int'(x % TBL);
  endfunction

  function automatic int find_slot(logic [IdW-1:0] h, logic [IdW-1:0] l);
    int s;
    s = bucket(h, l);
    for (int n = 0; n < TBL; n++) begin
      if (slots[s] == 0) return -1;
      if (ring_hi[slots[s] - 1] == h && ring_lo[slots[s] - 1] == l) return s;
      s = (s + 1) % TBL;
    end
    return -1;
  endfunction

  function automatic void place(int pos);
    int s;
    s = bucket(ring_hi[pos], ring_lo[pos]);
    for (int n = 0; n < TBL; n++) begin
      if (slots[s] == 0) begin
        slots[s] = 9'(pos + 1);
        return;
      end
      s = (s + 1) % TBL;
    end
  endfunction

  function automatic void unlink_id(logic [IdW-1:0] h, logic [IdW-1:0] l);
    int f, hole, nx, e, home, dn, dh;
    f = find_slot(h, l);
    if (f < 0) return;
    hole = f;
    nx = (hole + 1) % TBL;
    for (int n = 0; n < TBL; n++) begin
      e = slots[nx];
      if (e == 0) break;
      home = bucket(ring_hi[e - 1], ring_lo[e - 1]);
      dn = (nx + TBL - home) % TBL;
      dh = (hole + TBL - home) % TBL;
      if (dh < dn) begin
        slots[hole] = 9'(e);
        hole = nx;
      end
      nx = (nx + 1) % TBL;
    end
    slots[hole] = 0;
  endfunction

  function automatic answer_t predict(logic [1:0] act, logic [IdW-1:0] h,
                                      logic [IdW-1:0] l, logic [7:0] idx);
    answer_t a;
    int pos;
    a = '0;
    case (action_t'(act))
      ACT_ADD: begin
        if (find_slot(h, l) >= 0) a.hit = 1'b1;
        else begin
          if (held < RING) begin
            pos = (oldest + held) % RING;
            held++;
          end else begin
            pos = oldest;
            unlink_id(ring_hi[pos], ring_lo[pos]);
            oldest = (pos + 1) % RING;
          end
          ring_hi[pos] = h;
          ring_lo[pos] = l;
          place(pos);
        end
      end
      ACT_LOOKUP: a.hit = find_slot(h, l) >= 0;
      ACT_READ: begin
        if (idx < held) begin
          pos = (oldest + idx) % RING;
          a.index_ok = 1'b1;
          a.read_high = ring_hi[pos];
          a.read_low = ring_lo[pos];
        end
      end
      default: begin
        foreach (slots[i]) slots[i] = 0;
        held = 0;
        oldest = 0;
      end
    endcase
    a.entry_count = 9'(held);
    return a;
  endfunction

  initial begin
    foreach (slots[i]) slots[i] = 0;
    oldest = 0;
    held = 0;
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    answer_t want, got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{hit, index_ok, entry_count, read_high, read_low};
        if (answers.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result word: %p", got);
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid && in_ready)
        answers.push_back(predict(action, id_high, id_low, read_index));
      pending <= answers.size();
    end
  end
endmodule

[tb/sv/tb_top.sv]
// Top of the testbench for the identifier hash set core: clock, reset, stimulus with
// random gaps and stalls, watchdog and verdict. Depends on fehs_pkg, fehs_checker and the core.
module tb_top;
  import fehs_pkg::*;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     action = ACT_LOOKUP;
  logic [IdW-1:0] id_high = '0;
  logic [IdW-1:0] id_low = '0;
  logic [7:0]     read_index = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic           hit;
  logic           index_ok;
  logic [8:0]     entry_count;
  logic [IdW-1:0] read_high;
  logic [IdW-1:0] read_low;
  int             fail_count;
  int             pending;
  int             idle_cycles = 0;
  int             stall_left = 0;
  bit             quiet = 1'b0;
  logic [127:0]   known_ids [$];

  always #6 clk = ~clk;

  fifo_evicting_id_hash_set_core DUT (.*);

  fehs_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 40000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
    end
  end

  function automatic logic [127:0] fresh_id();
    logic [63:0] h, l;
    h = {$urandom, $urandom};
    l = {$urandom, $urandom};
    // Steer many words into a few buckets, some at the wrap of the table.
    if ($urandom_range(0, 1) == 0)
      l[8:0] = h[8:0] ^ (($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 5))
                                                      : 9'($urandom_range(508, 511)));
    return {h, l};
  endfunction

  function automatic logic [127:0] some_id(int known_pct);
    if (known_ids.size() > 0 && $urandom_range(0, 99) < known_pct)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    return fresh_id();
  endfunction

  task automatic send(action_t act, logic [127:0] ident, logic [7:0] idx);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    {id_high, id_low} <= ident;
    read_index <= idx;
    if (act == ACT_ADD) begin
      known_ids.push_back(ident);
      if (known_ids.size() > 400) void'(known_ids.pop_front());
    end
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        9: gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [127:0] a, b;
    int r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    a = fresh_id();
    b = fresh_id();
    send(ACT_READ, '0, 8'd0);
    send(ACT_ADD, a, 8'd0);
    send(ACT_ADD, a, 8'd0);
    send(ACT_LOOKUP, a, 8'd0);
    send(ACT_LOOKUP, b, 8'd255);
    send(ACT_ADD, '1, 8'd0);
    send(ACT_ADD, '0, 8'd0);
    send(ACT_ADD, {64'h0, 64'h1FF}, 8'd0);
    send(ACT_ADD, {64'h1FF, 64'h0}, 8'd0);
    send(ACT_LOOKUP, {64'h1FF, 64'h0}, 8'd0);
    send(ACT_READ, '1, 8'd0);
    send(ACT_READ, '0, 8'd4);
    send(ACT_READ, '0, 8'd5);
    send(ACT_READ, '0, 8'd255);
    send(ACT_CLEAR, '1, 8'd255);
    send(ACT_LOOKUP, a, 8'd0);
    send(ACT_READ, '0, 8'd0);
    send(ACT_ADD, a, 8'd0);
    send(ACT_READ, '0, 8'd0);
    for (int i = 0; i < 900; i++) begin
      if (i % 150 == 0) quiet = (i / 150) % 2 == 1;
      r = $urandom_range(0, 999);
      if (r < 540) send(ACT_ADD, some_id(20), 8'($urandom));
      else if (r < 760) send(ACT_LOOKUP, some_id(70), 8'($urandom));
      else if (r < 995) send(ACT_READ, {$urandom, $urandom, $urandom, $urandom},
                             ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255))
                                                         : 8'($urandom));
      else send(ACT_CLEAR, some_id(0), 8'($urandom));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/fehs_pkg.sv
rtl/core/fifo_evicting_id_hash_set_core.sv
tb/sv/fehs_checker.sv
tb/sv/tb_top.sv
